@@ hdl/reward_gated_hebbian_counter_top_assert.svh @@
// Assertion macros for the route plasticity table.
// RGHC_ASSERT_SAME checks the consequent in the same cycle as the antecedent.
// RGHC_ASSERT_NEXT checks the consequent in the cycle after the antecedent.
`ifndef REWARD_GATED_HEBBIAN_COUNTER_TOP_ASSERT_SVH
`define REWARD_GATED_HEBBIAN_COUNTER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define RGHC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define RGHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define RGHC_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define RGHC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/rghc_pkg.sv @@
`timescale 1ns / 1ps

package rghc_pkg;

    localparam int CNT_W   = 16;
    localparam int TRIT_W  = 2;
    localparam int CFG_W   = 15;
    localparam int CIDX_W  = 1;
    localparam int ROUTE_W = 6;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_COUNTER_LIMIT    = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_COMMIT_THRESHOLD = 1'b1;

    localparam logic [CFG_W-1:0] LIMIT_RST     = 15'd64;
    localparam logic [CFG_W-1:0] THRESHOLD_RST = 15'd16;

    // request kinds
    localparam logic REQ_REWARD = 1'b0;
    localparam logic REQ_PAIN   = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic clear_en;  // write zero at the sweep address
        logic capture;   // latch item, start table read
        logic execute;   // modify, write back, load result register
    } cmd_t;

    typedef struct packed {
        logic clear_last;   // sweep is at the final entry
        logic out_blocked;  // result register full and stalled
    } status_t;

endpackage

@@ hdl/rghc_ctrl.sv @@
`timescale 1ns / 1ps

module rghc_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  rghc_pkg::status_t status,
    output rghc_pkg::cmd_t    cmd,
    output logic             in_stall
);

    rghc_pkg::state_t state_reg;
    rghc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rghc_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rghc_pkg::ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = rghc_pkg::ST_IDLE;
                end
            end
            rghc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rghc_pkg::ST_EXEC;
                end
            end
            rghc_pkg::ST_EXEC:
            begin
                if (!status.out_blocked)
                begin
                    state_next = rghc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rghc_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            rghc_pkg::ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
            end
            rghc_pkg::ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            rghc_pkg::ST_EXEC:
            begin
                cmd.execute = !status.out_blocked;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ hdl/rghc_datapath.sv @@
`timescale 1ns / 1ps

module rghc_datapath
#(
    parameter int ROUTE_SLOTS = 64
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  rghc_pkg::cmd_t                         cmd,
    output rghc_pkg::status_t                      status,
    input  logic [rghc_pkg::CFG_W-1:0]             cfg_limit,
    input  logic [rghc_pkg::CFG_W-1:0]             cfg_threshold,
    input  logic                                  req_type,
    input  logic [rghc_pkg::ROUTE_W-1:0]           route_index,
    input  logic signed [rghc_pkg::TRIT_W-1:0]     source_trit,
    input  logic signed [rghc_pkg::TRIT_W-1:0]     sink_trit,
    input  logic                                  double_step,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [rghc_pkg::CNT_W-1:0]      counter_value,
    output logic signed [rghc_pkg::TRIT_W-1:0]     orientation,
    output logic                                  committed,
    output logic                                  skipped
);

    localparam int ADDR_W = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
    localparam int CMP_W  = ADDR_W + rghc_pkg::ROUTE_W + 1;
    localparam int WORD_W = rghc_pkg::CNT_W + rghc_pkg::TRIT_W;
    localparam int SUM_W  = rghc_pkg::CNT_W + 1;

    // entry word: {counter, sign}
    logic [WORD_W-1:0] route_mem [ROUTE_SLOTS];
    logic [WORD_W-1:0] rdata_reg;

    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;

    logic [CMP_W-1:0]  route_ext;
    logic [ADDR_W-1:0] route_addr;
    logic              route_ok;

    logic                              item_type_reg;
    logic [ADDR_W-1:0]                 item_addr_reg;
    logic                              item_ok_reg;
    logic [rghc_pkg::TRIT_W-1:0]       item_src_reg;
    logic [rghc_pkg::TRIT_W-1:0]       item_snk_reg;
    logic                              item_purpose_reg;

    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic signed [rghc_pkg::CNT_W-1:0]  cnt_out_reg;
    logic signed [rghc_pkg::TRIT_W-1:0] sgn_out_reg;
    logic                              commit_out_reg;
    logic                              skip_out_reg;

    logic signed [rghc_pkg::CNT_W-1:0]  cur_cnt;
    logic signed [rghc_pkg::TRIT_W-1:0] cur_sgn;
    logic signed [SUM_W-1:0]           delta;
    logic signed [SUM_W-1:0]           sum;
    logic signed [SUM_W-1:0]           sat;
    logic signed [SUM_W-1:0]           lim_pos;
    logic signed [SUM_W-1:0]           thr_pos;
    logic signed [rghc_pkg::CNT_W-1:0]  new_cnt;
    logic signed [rghc_pkg::TRIT_W-1:0] new_sgn;
    logic                              new_commit;
    logic                              new_skip;
    logic                              trits_live;
    logic                              do_write;

    assign route_ext  = CMP_W'(route_index);
    assign route_addr = route_ext[ADDR_W-1:0];
    assign route_ok   = route_ext < CMP_W'(ROUTE_SLOTS);

    // start-up sweep
    assign clr_addr_next     = cmd.clear_en ? clr_addr_reg + 1'b1 : clr_addr_reg;
    assign status.clear_last = clr_addr_reg == ADDR_W'(ROUTE_SLOTS - 1);
    assign status.out_blocked = out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_en)
        begin
            route_mem[clr_addr_reg] <= '0;
        end
        else if (do_write)
        begin
            route_mem[item_addr_reg] <= {new_cnt, new_sgn};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rdata_reg <= route_mem[route_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_type_reg    <= req_type;
            item_addr_reg    <= route_addr;
            item_ok_reg      <= route_ok;
            item_src_reg     <= source_trit;
            item_snk_reg     <= sink_trit;
            item_purpose_reg <= double_step;
        end
    end

    // read-modify of the captured entry
    always_comb
    begin
        cur_cnt    = rdata_reg[WORD_W-1:rghc_pkg::TRIT_W];
        cur_sgn    = rdata_reg[rghc_pkg::TRIT_W-1:0];
        trits_live = (item_src_reg != '0) && (item_snk_reg != '0);
        lim_pos    = SUM_W'({2'b00, cfg_limit});
        thr_pos    = SUM_W'({2'b00, cfg_threshold});

        // bit 1 of a trit marks a negative value
        if (item_src_reg[1] == item_snk_reg[1])
        begin
            delta = item_purpose_reg ? SUM_W'(2) : SUM_W'(1);
        end
        else
        begin
            delta = item_purpose_reg ? -SUM_W'(2) : -SUM_W'(1);
        end

        sum = SUM_W'(cur_cnt) + delta;
        priority if (sum > lim_pos)
        begin
            sat = lim_pos;
        end
        else if (sum < -lim_pos)
        begin
            sat = -lim_pos;
        end
        else
        begin
            sat = sum;
        end

        new_cnt    = cur_cnt;
        new_sgn    = cur_sgn;
        new_commit = 1'b0;
        new_skip   = 1'b0;

        priority if (!item_ok_reg)
        begin
            new_cnt  = '0;
            new_sgn  = '0;
            new_skip = 1'b1;
        end
        else if (item_type_reg == rghc_pkg::REQ_PAIN)
        begin
            priority if (cur_cnt > 0)
            begin
                new_cnt = cur_cnt - rghc_pkg::CNT_W'(1);
            end
            else if (cur_cnt < 0)
            begin
                new_cnt = cur_cnt + rghc_pkg::CNT_W'(1);
            end
            else
            begin
                new_cnt = cur_cnt;
            end
        end
        else if (!trits_live)
        begin
            new_skip = 1'b1;
        end
        else
        begin
            new_cnt = sat[rghc_pkg::CNT_W-1:0];
            priority if (sat >= thr_pos)
            begin
                new_sgn    = rghc_pkg::TRIT_W'(1);
                new_cnt    = '0;
                new_commit = 1'b1;
            end
            else if (sat <= -thr_pos)
            begin
                new_sgn    = -rghc_pkg::TRIT_W'(1);
                new_cnt    = '0;
                new_commit = 1'b1;
            end
            else
            begin
                new_sgn = cur_sgn;
            end
        end

        do_write = cmd.execute && item_ok_reg;
    end

    always_comb
    begin
        priority if (cmd.execute)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            cnt_out_reg    <= new_cnt;
            sgn_out_reg    <= new_sgn;
            commit_out_reg <= new_commit;
            skip_out_reg   <= new_skip;
        end
    end

    assign out_valid     = out_valid_reg;
    assign counter_value = cnt_out_reg;
    assign orientation   = sgn_out_reg;
    assign committed     = commit_out_reg;
    assign skipped       = skip_out_reg;

endmodule

@@ hdl/reward_gated_hebbian_counter_top.sv @@
`timescale 1ns / 1ps

// Route plasticity table: each of ROUTE_SLOTS routes holds a signed counter and a
// learned orientation trit in one on-chip memory word. A reward transaction moves
// the named route's counter up one when the source and sink trits agree and down
// one when they differ (two with double_step), saturating at the counter limit; a
// zero trit leaves the route alone and flags the result as skipped. Reaching the
// commit threshold writes the sign to the orientation and clears the counter. A
// pain transaction decays the counter one step toward zero. Every input
// transaction gives exactly one result transaction. An item goes through a table
// read on acceptance, then modify and write-back into the same entry, and the
// block takes no new item before the write-back of the last one; in_stall is
// high during the write-back, which stretches for as long as the previous result
// is still stalled in the output register. After reset a clearing pass zeroes the
// table, one entry a cycle; input is stalled then, configuration writes are
// taken. Registers (cfg_index): 0 counter limit (reset 64), 1 commit threshold
// (reset 16); write them only while no transaction is in flight.

module reward_gated_hebbian_counter_top
#(
    parameter int ROUTE_SLOTS = 64
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rghc_pkg::CIDX_W-1:0]            cfg_index,
    input  logic [rghc_pkg::CFG_W-1:0]             cfg_data,

    // request channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  req_type,
    input  logic [rghc_pkg::ROUTE_W-1:0]           route_index,
    input  logic signed [rghc_pkg::TRIT_W-1:0]     source_trit,
    input  logic signed [rghc_pkg::TRIT_W-1:0]     sink_trit,
    input  logic                                  double_step,

    // result channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [rghc_pkg::CNT_W-1:0]      counter_value,
    output logic signed [rghc_pkg::TRIT_W-1:0]     orientation,
    output logic                                  committed,
    output logic                                  skipped
);

`include "reward_gated_hebbian_counter_top_assert.svh"

    rghc_pkg::cmd_t    cmd;
    rghc_pkg::status_t status;

    logic [rghc_pkg::CFG_W-1:0] limit_reg;
    logic [rghc_pkg::CFG_W-1:0] limit_next;
    logic [rghc_pkg::CFG_W-1:0] threshold_reg;
    logic [rghc_pkg::CFG_W-1:0] threshold_next;

    // config writes never back-pressure
    assign cfg_ready = 1'b1;

    always_comb
    begin
        limit_next     = limit_reg;
        threshold_next = threshold_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rghc_pkg::CFG_COUNTER_LIMIT:
                begin
                    limit_next = cfg_data;
                end
                rghc_pkg::CFG_COMMIT_THRESHOLD:
                begin
                    threshold_next = cfg_data;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= rghc_pkg::LIMIT_RST;
            threshold_reg <= rghc_pkg::THRESHOLD_RST;
        end
        else
        begin
            limit_reg     <= limit_next;
            threshold_reg <= threshold_next;
        end
    end

    // sequencer: sweep, wait for item, read-modify-write
    rghc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // table memory, update arithmetic and output register
    rghc_datapath
    #(
        .ROUTE_SLOTS (ROUTE_SLOTS)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_limit      (limit_reg),
        .cfg_threshold  (threshold_reg),
        .req_type       (req_type),
        .route_index    (route_index),
        .source_trit    (source_trit),
        .sink_trit      (sink_trit),
        .double_step    (double_step),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .counter_value  (counter_value),
        .orientation    (orientation),
        .committed      (committed),
        .skipped        (skipped)
    );

    // an accepted item stalls the input in the following cycle (read then write)
    `RGHC_ASSERT_NEXT(a_one_item_in_flight, clk, rst_n, in_valid && !in_stall, in_stall)

    // a skipped transaction never commits
    `RGHC_ASSERT_SAME(a_skip_no_commit, clk, rst_n, out_valid && skipped, !committed)

    // a commit clears the counter and leaves a learned sign
    `RGHC_ASSERT_SAME(a_commit_clears, clk, rst_n, out_valid && committed,
        (counter_value == '0) && (orientation != '0))

endmodule
